>>> src/bpfm_pkg.sv
// shared constants, request and status codes, controller types for the frame manager
`timescale 1ns / 1ps
package bpfm_pkg;

  localparam int unsigned FRAMES    = 64;
  localparam int unsigned FRAME_W   = $clog2(FRAMES);
  localparam int unsigned CNT_W     = $clog2(FRAMES + 1);
  localparam int unsigned PAGE_BITS = 20;
  localparam int unsigned FIX_W     = 16;
  localparam int unsigned TOTAL_W   = 32;

  typedef enum logic [2:0] {
    REQ_FIX_READ  = 3'd0,
    REQ_FIX_WRITE = 3'd1,
    REQ_FIX_NEW   = 3'd2,
    REQ_UNFIX     = 3'd3,
    REQ_UNSET     = 3'd4,
    REQ_FLUSH     = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STS_OK           = 2'd0,
    STS_NOT_BUFFERED = 2'd1,
    STS_NO_VICTIM    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_UPDATE,
    ST_SIMPLE,
    ST_FL_FIRST,
    ST_FL_SCAN,
    ST_FL_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic fetch;
    logic update;
    logic simple;
    logic fl_step;
    logic fl_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic fl_any;
    logic fl_bit;
    logic fl_last;
  } dp_sts_t;

endpackage

>>> src/bpfm_ctrl.sv
// controller state machine sequencing lookups, updates and flush walks
`timescale 1ns / 1ps
module bpfm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2:0]        req_type_i,
  input  bpfm_pkg::dp_sts_t sts_i,
  output bpfm_pkg::dp_cmd_t cmd_o,
  output logic              busy_o
);

  bpfm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpfm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      bpfm_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (req_type_i <= bpfm_pkg::REQ_UNFIX) begin
            state_d = bpfm_pkg::ST_SCAN;
          end else if (req_type_i == bpfm_pkg::REQ_FLUSH) begin
            state_d = bpfm_pkg::ST_FL_FIRST;
          end else begin
            state_d = bpfm_pkg::ST_SIMPLE;
          end
        end
      end
      bpfm_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = bpfm_pkg::ST_FETCH;
        end
      end
      bpfm_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = bpfm_pkg::ST_UPDATE;
      end
      bpfm_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = bpfm_pkg::ST_IDLE;
      end
      bpfm_pkg::ST_SIMPLE: begin
        cmd_o.simple = 1'b1;
        state_d      = bpfm_pkg::ST_IDLE;
      end
      bpfm_pkg::ST_FL_FIRST: begin
        if (!sts_i.fl_any) begin
          cmd_o.simple = 1'b1;
          state_d      = bpfm_pkg::ST_IDLE;
        end else begin
          state_d = bpfm_pkg::ST_FL_SCAN;
        end
      end
      bpfm_pkg::ST_FL_SCAN: begin
        if (sts_i.fl_bit) begin
          state_d = bpfm_pkg::ST_FL_EMIT;
        end else begin
          cmd_o.fl_step = 1'b1;
        end
      end
      bpfm_pkg::ST_FL_EMIT: begin
        cmd_o.fl_emit = 1'b1;
        state_d = sts_i.fl_last ? bpfm_pkg::ST_IDLE : bpfm_pkg::ST_FL_SCAN;
      end
      default: begin
        state_d = bpfm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/bpfm_dp.sv
// datapath: tag and fix count memories, frame flags, lru position cells, counters, result regs
`timescale 1ns / 1ps
module bpfm_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bpfm_pkg::dp_cmd_t                cmd_i,
  output bpfm_pkg::dp_sts_t                sts_o,
  input  logic [2:0]                       req_type_i,
  input  logic [19:0]                      page_i,
  input  logic [5:0]                       frame_index_i,
  output logic                             valid_o,
  output logic [5:0]                       frame_o,
  output logic                             hit_o,
  output logic [1:0]                       status_o,
  output logic                             load_request_o,
  output logic                             writeback_valid_o,
  output logic [19:0]                      writeback_page_o,
  output logic [5:0]                       writeback_frame_o,
  output logic [31:0]                      hits_so_far_o,
  output logic [31:0]                      accesses_so_far_o,
  output logic                             last_o
);

  localparam int unsigned FW = bpfm_pkg::FRAME_W;
  localparam int unsigned CW = bpfm_pkg::CNT_W;
  localparam int unsigned PW = bpfm_pkg::PAGE_BITS;
  localparam int unsigned XW = bpfm_pkg::FIX_W;
  localparam int unsigned TW = bpfm_pkg::TOTAL_W;
  localparam int unsigned NF = bpfm_pkg::FRAMES;

  // memories
  logic [PW-1:0] tag_mem [NF];
  logic [XW-1:0] fix_mem [NF];
  logic [PW-1:0] tag_rd_q;
  logic [XW-1:0] fix_rd_q;
  logic          tag_we, fix_we;
  logic [FW-1:0] tag_ra;
  logic [PW-1:0] tag_wd;
  logic [XW-1:0] fix_wd;

  // request and scan state
  logic [2:0]    req_q;
  logic [PW-1:0] page_q;
  logic [FW-1:0] fi_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          found_q, found_d, free_found_q, free_found_d;
  logic [FW-1:0] hit_f_q, hit_f_d, free_f_q, free_f_d, head_f_q, head_f_d;
  logic [FW-1:0] f_q, f_sel, j;

  // frame flags and lru cells
  logic [NF-1:0] in_use_q, in_use_d, dirty_q, dirty_d, in_lru_q, in_lru_d;
  logic [NF-1:0] head_vec, pend;
  logic [FW-1:0] pos_q [NF];
  logic [FW-1:0] pos_d [NF];
  logic [CW-1:0] lru_len_q, lru_len_d, len_after;
  logic          rem_en, push_en, do_rem;
  logic [FW-1:0] rem_pos;

  logic [TW-1:0] hit_total_q, hit_total_d, acc_total_q, acc_total_d;

  // result
  logic          res_valid_q, res_valid_d;
  logic [5:0]    res_frame_q, res_frame_d, res_wbf_q, res_wbf_d;
  logic          res_hit_q, res_hit_d, res_load_q, res_load_d, res_wbv_q, res_wbv_d;
  logic          res_last_q, res_last_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [19:0]   res_wbp_q, res_wbp_d;

  logic is_fix, victim, avail;
  logic [XW-1:0] fix_dec;

  assign j      = cnt_q[FW-1:0] - FW'(1);
  assign f_sel  = found_q ? hit_f_q : (free_found_q ? free_f_q : head_f_q);
  assign tag_ra = cmd_i.fetch ? f_sel : cnt_q[FW-1:0];
  assign pend   = in_use_q & dirty_q;
  assign is_fix = (req_q <= bpfm_pkg::REQ_FIX_NEW);
  assign victim = !found_q && !free_found_q;
  assign avail  = found_q || free_found_q || (lru_len_q != '0);
  assign fix_dec = (fix_rd_q != '0) ? fix_rd_q - XW'(1) : fix_rd_q;

  assign sts_o.scan_done = (cnt_q == CW'(NF));
  assign sts_o.fl_any    = |pend;
  assign sts_o.fl_bit    = pend[cnt_q[FW-1:0]];
  assign sts_o.fl_last   = ((pend >> cnt_q[FW-1:0]) >> 1) == '0;

  always_comb begin
    for (int g = 0; g < NF; g++) begin
      head_vec[g] = in_lru_q[g] && (pos_q[g] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[f_q] <= tag_wd;
    end
    tag_rd_q <= tag_mem[tag_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fix_we) begin
      fix_mem[f_q] <= fix_wd;
    end
    fix_rd_q <= fix_mem[f_sel];
  end

  // scan bookkeeping
  always_comb begin
    cnt_d        = cnt_q;
    found_d      = found_q;
    free_found_d = free_found_q;
    hit_f_d      = hit_f_q;
    free_f_d     = free_f_q;
    head_f_d     = head_f_q;
    if (cmd_i.load) begin
      cnt_d        = '0;
      found_d      = 1'b0;
      free_found_d = 1'b0;
    end else if (cmd_i.scan) begin
      cnt_d = cnt_q + CW'(1);
      if (cnt_q != '0) begin
        if (in_use_q[j] && (tag_rd_q == page_q) && !found_q) begin
          found_d = 1'b1;
          hit_f_d = j;
        end
        if (!in_use_q[j] && !free_found_q) begin
          free_found_d = 1'b1;
          free_f_d     = j;
        end
        if (head_vec[j]) begin
          head_f_d = j;
        end
      end
    end else if (cmd_i.fl_step || cmd_i.fl_emit) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  // request update and result
  always_comb begin
    tag_we       = 1'b0;
    fix_we       = 1'b0;
    tag_wd       = page_q;
    fix_wd       = XW'(1);
    in_use_d     = in_use_q;
    dirty_d      = dirty_q;
    rem_en       = 1'b0;
    push_en      = 1'b0;
    hit_total_d  = hit_total_q;
    acc_total_d  = acc_total_q;
    res_valid_d  = 1'b0;
    res_frame_d  = '0;
    res_hit_d    = 1'b0;
    res_status_d = bpfm_pkg::STS_OK;
    res_load_d   = 1'b0;
    res_wbv_d    = 1'b0;
    res_wbp_d    = '0;
    res_wbf_d    = '0;
    res_last_d   = 1'b1;
    if (cmd_i.update) begin
      res_valid_d = 1'b1;
      if (is_fix) begin
        if (found_q) begin
          fix_we      = 1'b1;
          fix_wd      = (fix_rd_q == '1) ? fix_rd_q : fix_rd_q + XW'(1);
          rem_en      = 1'b1;
          hit_total_d = hit_total_q + TW'(1);
          acc_total_d = acc_total_q + TW'(1);
          if (req_q == bpfm_pkg::REQ_FIX_WRITE) begin
            dirty_d[f_q] = 1'b1;
          end
          res_frame_d = 6'(f_q);
          res_hit_d   = 1'b1;
        end else if (avail) begin
          if (victim) begin
            rem_en = 1'b1;
            if (dirty_q[f_q]) begin
              res_wbv_d = 1'b1;
              res_wbp_d = 20'(tag_rd_q);
              res_wbf_d = 6'(f_q);
            end
          end
          tag_we         = 1'b1;
          fix_we         = 1'b1;
          fix_wd         = XW'(1);
          in_use_d[f_q]  = 1'b1;
          dirty_d[f_q]   = (req_q == bpfm_pkg::REQ_FIX_WRITE);
          acc_total_d    = acc_total_q + TW'(1);
          res_frame_d    = 6'(f_q);
          res_load_d     = (req_q != bpfm_pkg::REQ_FIX_NEW);
        end else begin
          res_status_d = bpfm_pkg::STS_NO_VICTIM;
        end
      end else begin
        if (!found_q) begin
          res_status_d = bpfm_pkg::STS_NOT_BUFFERED;
        end else begin
          fix_we      = 1'b1;
          fix_wd      = fix_dec;
          if (fix_dec == '0) begin
            rem_en  = 1'b1;
            push_en = 1'b1;
          end
          res_frame_d = 6'(f_q);
        end
      end
    end else if (cmd_i.simple) begin
      res_valid_d = 1'b1;
      if (req_q == bpfm_pkg::REQ_UNSET) begin
        res_frame_d = 6'(fi_q);
        if (in_use_q[fi_q]) begin
          dirty_d[fi_q] = 1'b0;
        end
      end
    end else if (cmd_i.fl_emit) begin
      res_valid_d                = 1'b1;
      res_wbv_d                  = 1'b1;
      res_wbp_d                  = 20'(tag_rd_q);
      res_wbf_d                  = 6'(cnt_q[FW-1:0]);
      res_last_d                 = sts_o.fl_last;
      dirty_d[cnt_q[FW-1:0]]     = 1'b0;
    end
  end

  // lru position cells
  always_comb begin
    rem_pos   = pos_q[f_q];
    do_rem    = rem_en && in_lru_q[f_q];
    len_after = lru_len_q - CW'(do_rem);
    in_lru_d  = in_lru_q;
    for (int g = 0; g < NF; g++) begin
      pos_d[g] = pos_q[g];
      if (do_rem && in_lru_q[g] && (pos_q[g] > rem_pos)) begin
        pos_d[g] = pos_q[g] - FW'(1);
      end
    end
    if (push_en) begin
      in_lru_d[f_q] = 1'b1;
      pos_d[f_q]    = len_after[FW-1:0];
    end else if (rem_en) begin
      in_lru_d[f_q] = 1'b0;
    end
    lru_len_d = len_after + CW'(push_en);
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NF; g++) begin
      pos_q[g] <= pos_d[g];
    end
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      page_q <= page_i[PW-1:0];
      fi_q   <= frame_index_i[FW-1:0];
    end
    if (cmd_i.fetch) begin
      f_q <= f_sel;
    end
    hit_f_q      <= hit_f_d;
    free_f_q     <= free_f_d;
    head_f_q     <= head_f_d;
    res_frame_q  <= res_frame_d;
    res_hit_q    <= res_hit_d;
    res_status_q <= res_status_d;
    res_load_q   <= res_load_d;
    res_wbv_q    <= res_wbv_d;
    res_wbp_q    <= res_wbp_d;
    res_wbf_q    <= res_wbf_d;
    res_last_q   <= res_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      in_use_q     <= '0;
      dirty_q      <= '0;
      in_lru_q     <= '0;
      lru_len_q    <= '0;
      hit_total_q  <= '0;
      acc_total_q  <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      in_use_q     <= in_use_d;
      dirty_q      <= dirty_d;
      in_lru_q     <= in_lru_d;
      lru_len_q    <= lru_len_d;
      hit_total_q  <= hit_total_d;
      acc_total_q  <= acc_total_d;
      res_valid_q  <= res_valid_d;
    end
  end

  assign valid_o           = res_valid_q;
  assign frame_o           = res_frame_q;
  assign hit_o             = res_hit_q;
  assign status_o          = res_status_q;
  assign load_request_o    = res_load_q;
  assign writeback_valid_o = res_wbv_q;
  assign writeback_page_o  = res_wbp_q;
  assign writeback_frame_o = res_wbf_q;
  assign hits_so_far_o     = hit_total_q;
  assign accesses_so_far_o = acc_total_q;
  assign last_o            = res_last_q;

  a_lru_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lru_len_q <= CW'(NF))
    else $error("lru length beyond frame count");

  a_lru_len_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(in_lru_q) == 32'(lru_len_q))
    else $error("lru length disagrees with listed frames");

  a_lru_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_lru_q & ~in_use_q) == '0)
    else $error("frame on lru list not in use");

  a_wb_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_wbv_q |-> res_status_q == bpfm_pkg::STS_OK)
    else $error("writeback with error status");

endmodule

>>> src/buffer_pool_frame_manager_lru_unit.sv
// Buffer pool frame manager with LRU replacement over 64 frames.
// A request is taken when start_i is high and busy_o is low: req_type_i selects fix read,
// fix write, fix new, unfix, unset dirty or flush; page_i and frame_index_i go with it.
// Each result shows on the result ports for exactly one cycle with valid_o high;
// last_o marks the final result of a request. The receiver cannot stall results.
// Fix and unfix walk the tag memory frame by frame through its single registered read
// port, then read the fix count and end in the update state.
// The result appears the cycle after the update; busy_o drops in that same cycle.
// Unset dirty and undefined codes pass through the simple state only. Flush walks
// the frames one per cycle, pausing on each dirty frame to emit one writeback result
// for it, in ascending frame order; with no dirty frame it gives a single empty result.
// hits_so_far_o and accesses_so_far_o hold the running fix counters.
// Reset clears all frame flags, the LRU list and the counters; no clearing pass is needed.
`timescale 1ns / 1ps
module buffer_pool_frame_manager_lru_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [19:0] page_i,
  input  logic [5:0]  frame_index_i,
  output logic        valid_o,
  output logic [5:0]  frame_o,
  output logic        hit_o,
  output logic [1:0]  status_o,
  output logic        load_request_o,
  output logic        writeback_valid_o,
  output logic [19:0] writeback_page_o,
  output logic [5:0]  writeback_frame_o,
  output logic [31:0] hits_so_far_o,
  output logic [31:0] accesses_so_far_o,
  output logic        last_o
);

  bpfm_pkg::dp_cmd_t cmd;
  bpfm_pkg::dp_sts_t sts;

  bpfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  bpfm_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_type_i        (req_type_i),
    .page_i            (page_i),
    .frame_index_i     (frame_index_i),
    .valid_o           (valid_o),
    .frame_o           (frame_o),
    .hit_o             (hit_o),
    .status_o          (status_o),
    .load_request_o    (load_request_o),
    .writeback_valid_o (writeback_valid_o),
    .writeback_page_o  (writeback_page_o),
    .writeback_frame_o (writeback_frame_o),
    .hits_so_far_o     (hits_so_far_o),
    .accesses_so_far_o (accesses_so_far_o),
    .last_o            (last_o)
  );

endmodule

>>> test/tb_top.sv
// self-checking testbench for the buffer pool frame manager with lru replacement
`timescale 1ns / 1ps
module tb_top;

  localparam logic [2:0] REQ_UNDEF_LO = 3'd6;
  localparam logic [2:0] REQ_UNDEF_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned POOL_N = 80;

  typedef struct {
    logic [2:0]  req;
    logic [19:0] page;
    logic [5:0]  fidx;
    int          gap;
    bit          drain;
  } request_t;

  typedef struct {
    logic [5:0]  frame;
    logic        hit;
    logic [1:0]  status;
    logic        load;
    logic        wb_valid;
    logic [19:0] wb_page;
    logic [5:0]  wb_frame;
    logic [31:0] hits;
    logic [31:0] accesses;
    logic        last;
  } outcome_t;

  logic        clk_i, rst_ni, start_i, busy_o;
  logic [2:0]  req_type_i;
  logic [19:0] page_i;
  logic [5:0]  frame_index_i;
  logic        valid_o, hit_o, load_request_o, writeback_valid_o, last_o;
  logic [5:0]  frame_o, writeback_frame_o;
  logic [1:0]  status_o;
  logic [19:0] writeback_page_o;
  logic [31:0] hits_so_far_o, accesses_so_far_o;

  buffer_pool_frame_manager_lru_unit dut (.*);

  // model of the frame table
  logic [19:0] tag_mem [bpfm_pkg::FRAMES];
  bit          in_use  [bpfm_pkg::FRAMES];
  logic [15:0] fix_cnt [bpfm_pkg::FRAMES];
  bit          dirty   [bpfm_pkg::FRAMES];
  int          lru_q[$];
  logic [31:0] hit_total, access_total;

  request_t    pending_q[$];
  outcome_t    outcome_q[$];
  request_t    cur;
  bit          have_cur, took_q;
  int          gap_left, errors, results_seen, writebacks_seen, victims_denied;
  int          req_count [8];
  int unsigned cycles;
  logic [19:0] pool [POOL_N];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int find_frame(logic [19:0] p);
    for (int i = 0; i < bpfm_pkg::FRAMES; i++)
      if (in_use[i] && tag_mem[i] == p) return i;
    return -1;
  endfunction

  function automatic void lru_drop(int f);
    foreach (lru_q[i])
      if (lru_q[i] == f) begin
        lru_q.delete(i);
        return;
      end
  endfunction

  function automatic void add_outcome(int frame, bit hit, bpfm_pkg::status_e st, bit load,
                                      bit wbv, logic [19:0] wbp, int wbf, bit last);
    outcome_t o;
    o.frame = frame[5:0]; o.hit = hit; o.status = st; o.load = load;
    o.wb_valid = wbv; o.wb_page = wbp; o.wb_frame = wbf[5:0];
    o.hits = hit_total; o.accesses = access_total; o.last = last;
    outcome_q.insert(outcome_q.size(), o);
  endfunction

  function automatic void apply_request(logic [2:0] req, logic [19:0] p, logic [5:0] fi);
    int f, total, k;
    bit wbv;
    logic [19:0] wbp;
    int wbf;
    req_count[req]++;
    case (req)
      bpfm_pkg::REQ_FIX_READ, bpfm_pkg::REQ_FIX_WRITE, bpfm_pkg::REQ_FIX_NEW: begin
        f = find_frame(p);
        if (f >= 0) begin
          if (fix_cnt[f] != 16'hFFFF) fix_cnt[f]++;
          lru_drop(f);
          hit_total++;
          access_total++;
          if (req == bpfm_pkg::REQ_FIX_WRITE) dirty[f] = 1;
          add_outcome(f, 1, bpfm_pkg::STS_OK, 0, 0, '0, 0, 1);
        end else begin
          wbv = 0; wbp = '0; wbf = 0;
          for (f = 0; f < bpfm_pkg::FRAMES; f++) if (!in_use[f]) break;
          if (f == bpfm_pkg::FRAMES) begin
            if (lru_q.size() == 0) begin
              victims_denied++;
              add_outcome(0, 0, bpfm_pkg::STS_NO_VICTIM, 0, 0, '0, 0, 1);
              return;
            end
            f = lru_q[0];
            lru_q.delete(0);
            if (dirty[f]) begin
              wbv = 1; wbp = tag_mem[f]; wbf = f;
            end
          end
          tag_mem[f] = p;
          in_use[f] = 1;
          fix_cnt[f] = 1;
          dirty[f] = (req == bpfm_pkg::REQ_FIX_WRITE);
          access_total++;
          add_outcome(f, 0, bpfm_pkg::STS_OK, req != bpfm_pkg::REQ_FIX_NEW, wbv, wbp, wbf, 1);
        end
      end
      bpfm_pkg::REQ_UNFIX: begin
        f = find_frame(p);
        if (f < 0) begin
          add_outcome(0, 0, bpfm_pkg::STS_NOT_BUFFERED, 0, 0, '0, 0, 1);
        end else begin
          if (fix_cnt[f] != 0) fix_cnt[f]--;
          if (fix_cnt[f] == 0) begin
            lru_drop(f);
            lru_q.insert(lru_q.size(), f);
          end
          add_outcome(f, 0, bpfm_pkg::STS_OK, 0, 0, '0, 0, 1);
        end
      end
      bpfm_pkg::REQ_UNSET: begin
        if (in_use[fi]) dirty[fi] = 0;
        add_outcome(int'(fi), 0, bpfm_pkg::STS_OK, 0, 0, '0, 0, 1);
      end
      bpfm_pkg::REQ_FLUSH: begin
        total = 0;
        for (int i = 0; i < bpfm_pkg::FRAMES; i++) if (in_use[i] && dirty[i]) total++;
        if (total == 0) add_outcome(0, 0, bpfm_pkg::STS_OK, 0, 0, '0, 0, 1);
        k = 0;
        for (int i = 0; i < bpfm_pkg::FRAMES; i++)
          if (in_use[i] && dirty[i]) begin
            dirty[i] = 0;
            k++;
            add_outcome(0, 0, bpfm_pkg::STS_OK, 0, 1, tag_mem[i], i, k == total);
          end
      end
      default: add_outcome(0, 0, bpfm_pkg::STS_OK, 0, 0, '0, 0, 1);
    endcase
  endfunction

  function automatic void queue_request(logic [2:0] req, logic [19:0] p, logic [5:0] fi,
                                        bit drain = 0);
    request_t r;
    r.req = req; r.page = p; r.fidx = fi; r.drain = drain;
    if ($urandom_range(0, 9) < 4) r.gap = 0;
    else if ($urandom_range(0, 9) < 8) r.gap = $urandom_range(1, 3);
    else r.gap = $urandom_range(10, 120);
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // accept requests and predict their results
  always @(posedge clk_i) begin
    took_q <= start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) apply_request(req_type_i, page_i, frame_index_i);
  end

  // result monitor
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && valid_o) begin
      results_seen++;
      if (writeback_valid_o) writebacks_seen++;
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result, frame %0h", $time, frame_o);
        errors++;
      end else begin
        e = outcome_q[0];
        outcome_q.delete(0);
        compare_field("frame", 32'(e.frame), 32'(frame_o));
        compare_field("hit", 32'(e.hit), 32'(hit_o));
        compare_field("status", 32'(e.status), 32'(status_o));
        compare_field("load_request", 32'(e.load), 32'(load_request_o));
        compare_field("writeback_valid", 32'(e.wb_valid), 32'(writeback_valid_o));
        compare_field("writeback_page", 32'(e.wb_page), 32'(writeback_page_o));
        compare_field("writeback_frame", 32'(e.wb_frame), 32'(writeback_frame_o));
        compare_field("hits_so_far", e.hits, hits_so_far_o);
        compare_field("accesses_so_far", e.accesses, accesses_so_far_o);
        compare_field("last", 32'(e.last), 32'(last_o));
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    bit go;
    go = 0;
    if (rst_ni) begin
      if (start_i && !took_q) begin
        go = 1;
      end else begin
        if (!have_cur && pending_q.size() > 0) begin
          cur = pending_q[0];
          pending_q.delete(0);
          have_cur = 1;
          gap_left = cur.gap;
        end
        if (have_cur) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!(cur.drain && outcome_q.size() != 0)) begin
            req_type_i <= cur.req;
            page_i <= cur.page;
            frame_index_i <= cur.fidx;
            have_cur = 0;
            go = 1;
          end
        end
      end
      start_i <= go;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("buffer_pool_frame_manager_lru_unit test failed");
      $finish;
    end
  end

  initial begin
    logic [2:0] op;
    clk_i = 0; rst_ni = 0; start_i = 0;
    req_type_i = bpfm_pkg::REQ_FIX_READ; page_i = '0; frame_index_i = '0;
    for (int i = 0; i < bpfm_pkg::FRAMES; i++) begin
      in_use[i] = 0; fix_cnt[i] = '0; dirty[i] = 0; tag_mem[i] = '0;
    end
    hit_total = '0; access_total = '0;
    for (int i = 0; i < POOL_N; i++) pool[i] = {13'($urandom), 7'(i)};

    // directed part
    queue_request(bpfm_pkg::REQ_FIX_READ, 20'h00000, 6'd0);
    queue_request(bpfm_pkg::REQ_FIX_WRITE, 20'hFFFFF, 6'd63);
    queue_request(bpfm_pkg::REQ_FIX_NEW, 20'h12345, 6'd0);
    queue_request(bpfm_pkg::REQ_FIX_READ, 20'h00000, 6'd0);
    queue_request(bpfm_pkg::REQ_UNFIX, 20'h00000, 6'd0);
    queue_request(bpfm_pkg::REQ_UNFIX, 20'h00000, 6'd0);
    queue_request(bpfm_pkg::REQ_UNFIX, 20'h00000, 6'd0);
    queue_request(bpfm_pkg::REQ_UNFIX, 20'hABCDE, 6'd0);
    queue_request(bpfm_pkg::REQ_UNSET, 20'h00000, 6'd1);
    queue_request(bpfm_pkg::REQ_UNSET, 20'hFFFFF, 6'd63);
    queue_request(bpfm_pkg::REQ_FLUSH, 20'h00000, 6'd0);
    queue_request(bpfm_pkg::REQ_FIX_WRITE, 20'h00000, 6'd0, 1);
    queue_request(bpfm_pkg::REQ_FLUSH, 20'h00000, 6'd0);
    queue_request(REQ_UNDEF_LO, 20'hFFFFF, 6'd63);
    queue_request(REQ_UNDEF_HI, 20'h55555, 6'd21);
    queue_request(bpfm_pkg::REQ_FIX_WRITE, 20'h12345, 6'd0);
    queue_request(bpfm_pkg::REQ_FIX_WRITE, 20'hFFFFF, 6'd0);
    queue_request(bpfm_pkg::REQ_FIX_WRITE, 20'h0F0F0, 6'd0);
    queue_request(bpfm_pkg::REQ_FLUSH, 20'h00000, 6'd0);
    queue_request(bpfm_pkg::REQ_FIX_WRITE, 20'h00000, 6'd0);

    // fill the pool until no victim is left
    for (int i = 0; i < 66; i++)
      queue_request(3'($urandom_range(0, 2)), pool[i], 6'($urandom));
    queue_request(bpfm_pkg::REQ_FLUSH, 20'h00000, 6'd0, 1);

    // mixed traffic over the same page set
    for (int i = 0; i < 50; i++) begin
      op = $urandom_range(0, 99) < 45 ? 3'($urandom_range(0, 2)) :
           $urandom_range(0, 99) < 65 ? bpfm_pkg::REQ_UNFIX : 3'($urandom_range(4, 7));
      queue_request(op, pool[$urandom_range(0, POOL_N - 1)], 6'($urandom),
                    $urandom_range(0, 19) == 0);
    end
    queue_request(bpfm_pkg::REQ_FLUSH, 20'h00000, 6'd0, 1);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    wait (pending_q.size() == 0 && !have_cur);
    @(negedge clk_i);
    wait (!start_i && outcome_q.size() == 0);
    repeat (80) @(posedge clk_i);

    $display("covered %0d fixes, %0d unfixes, %0d unset, %0d flushes, %0d undefined codes",
             req_count[0] + req_count[1] + req_count[2], req_count[3], req_count[4],
             req_count[5], req_count[6] + req_count[7]);
    $display("checked %0d results, %0d writebacks, %0d misses without victim",
             results_seen, writebacks_seen, victims_denied);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("buffer_pool_frame_manager_lru_unit test passed");
    end else begin
      $display("buffer_pool_frame_manager_lru_unit test failed");
    end
    $finish;
  end

endmodule
